FILE: rtl/i2c_master_transfer_sequencer_assert.svh
// Assertion macros for the I2C master transfer sequencer.
// Included by the top level; the forms under SYNTHESIS expand to nothing.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define I2CSEQ_ASSERT_SAME(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CSEQ_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`else

`define I2CSEQ_ASSERT_SAME(lbl, clk, rst_n, ant, cons, msg)
`define I2CSEQ_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg)

`endif

`endif

FILE: rtl/i2c_seq_pkg.sv
// Shared types and constants of the I2C master transfer sequencer.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package i2c_seq_pkg;

  localparam int REQ_W       = 3;
  localparam int ACT_W       = 3;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  // Request kinds carried in in_tuser.
  localparam logic [REQ_W-1:0] REQ_START = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TXRDY = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RXBYTE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_XFER_DONE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP = 3'd4;
  localparam logic [REQ_W-1:0] REQ_NACK = 3'd5;

  // Action codes carried in out_tuser.
  localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SEND = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PROG = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STOP = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLR_STOP = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLR_NACK = 3'd5;
  localparam logic [ACT_W-1:0] ACT_DELIVER = 3'd6;
  localparam logic [ACT_W-1:0] ACT_REJECT = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TX_PROG,
    ST_RD_ADDR,
    ST_DELIVER
  } seq_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;
    logic exec;
    logic prog2;
    logic rd_en;
    logic deliver;
  } seq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic slot_free;
    logic more_tx;
    logic more_rx;
    logic del_last;
  } seq_status_t;

endpackage

`default_nettype wire

FILE: rtl/i2c_seq_dp.sv
// Datapath of the I2C master transfer sequencer: item register, transfer
// counters, receive store and the output register. Depends on i2c_seq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2c_seq_dp
  import i2c_seq_pkg::*;
#(
  parameter int RX_STORE_DEPTH = 32,
  parameter int MAX_CHUNK      = 255
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire seq_cmd_t               cmd,
  output seq_status_t                 status,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [REQ_W-1:0]       in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [ACT_W-1:0]            out_tuser,
  output logic                        out_tlast
);

  localparam int IDXW = $clog2(RX_STORE_DEPTH + 1);
  localparam int AW   = (RX_STORE_DEPTH > 1) ? $clog2(RX_STORE_DEPTH) : 1;

  // Latched input item.
  logic [REQ_W-1:0] item_req_r;
  logic [6:0]       item_addr_r;
  logic [15:0]      item_scount_r;
  logic [15:0]      item_rcount_r;
  logic             item_busy_r;
  logic             item_reload_r;
  logic [7:0]       item_tx_r;
  logic [7:0]       item_rx_r;

  // Transfer state.
  logic             reading_r, reading_nxt;
  logic [6:0]       held_addr_r, held_addr_nxt;
  logic [15:0]      tx_rem_r, tx_rem_nxt;
  logic [15:0]      rx_rem_r, rx_rem_nxt;
  logic [15:0]      rx_total_r, rx_total_nxt;
  logic [IDXW-1:0]  wr_idx_r, wr_idx_nxt;
  logic [IDXW-1:0]  del_idx_r, del_idx_nxt;
  logic [IDXW-1:0]  del_cnt_r, del_cnt_nxt;

  logic [7:0] mem [RX_STORE_DEPTH];
  logic [7:0] rd_data_r;
  logic       mem_we;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [ACT_W-1:0]       out_tuser_r;
  logic                   out_tlast_r;

  // Result being formed this cycle.
  logic             res_load;
  logic [ACT_W-1:0] res_act;
  logic [7:0]       res_tx;
  logic [7:0]       res_chunk;
  logic             res_reload;
  logic             res_dir;
  logic [6:0]       res_addr;
  logic             res_start;
  logic [7:0]       res_rx;
  logic             res_ovf;
  logic             res_last;

  logic             use_prog;
  logic [15:0]      pg_rem;

  logic [15:0]      tx_dec;
  logic [15:0]      rx_dec;
  logic [IDXW-1:0]  cur_cnt;
  logic             store_full;
  logic             slot_free;

  assign slot_free  = !out_tvalid_r || out_tready;
  assign tx_dec     = (tx_rem_r != 16'd0) ? tx_rem_r - 16'd1 : tx_rem_r;
  assign rx_dec     = (rx_rem_r != 16'd0) ? rx_rem_r - 16'd1 : rx_rem_r;
  assign store_full = !(wr_idx_r < IDXW'(RX_STORE_DEPTH));
  assign cur_cnt    = (rx_total_r > 16'(RX_STORE_DEPTH)) ? IDXW'(RX_STORE_DEPTH)
                                                         : rx_total_r[IDXW-1:0];

  assign status.slot_free = slot_free;
  assign status.more_tx   = (item_req_r == REQ_TXRDY) && item_reload_r;
  assign status.more_rx   = (item_req_r == REQ_STOP) && reading_r && (cur_cnt != '0);
  assign status.del_last  = (del_idx_r + IDXW'(1)) == del_cnt_r;

  always_comb begin
    res_load      = 1'b0;
    res_act       = ACT_NONE;
    res_tx        = 8'd0;
    res_rx        = 8'd0;
    res_ovf       = 1'b0;
    res_last      = 1'b1;
    res_dir       = 1'b0;
    res_start     = 1'b0;
    res_addr      = held_addr_r;
    use_prog      = 1'b0;
    pg_rem        = 16'd0;
    mem_we        = 1'b0;
    reading_nxt   = reading_r;
    held_addr_nxt = held_addr_r;
    tx_rem_nxt    = tx_rem_r;
    rx_rem_nxt    = rx_rem_r;
    rx_total_nxt  = rx_total_r;
    wr_idx_nxt    = wr_idx_r;
    del_idx_nxt   = del_idx_r;
    del_cnt_nxt   = del_cnt_r;

    if (cmd.exec) begin
      case (item_req_r)
        REQ_START: begin
          res_load = 1'b1;
          if (item_busy_r || (item_scount_r == 16'd0 && item_rcount_r == 16'd0)) begin
            res_act = ACT_REJECT;
          end else begin
            held_addr_nxt = item_addr_r;
            tx_rem_nxt    = item_scount_r;
            rx_rem_nxt    = item_rcount_r;
            rx_total_nxt  = item_rcount_r;
            wr_idx_nxt    = '0;
            reading_nxt   = (item_scount_r == 16'd0);
            use_prog      = 1'b1;
            res_addr      = item_addr_r;
            res_start     = 1'b1;
            res_dir       = (item_scount_r == 16'd0);
            pg_rem        = (item_scount_r != 16'd0) ? item_scount_r : item_rcount_r;
          end
        end
        REQ_TXRDY: begin
          res_load   = 1'b1;
          res_act    = ACT_SEND;
          res_tx     = item_tx_r;
          res_last   = !item_reload_r;
          tx_rem_nxt = tx_dec;
        end
        REQ_RXBYTE: begin
          res_load   = 1'b1;
          res_ovf    = store_full;
          rx_rem_nxt = rx_dec;
          if (!store_full) begin
            mem_we     = 1'b1;
            wr_idx_nxt = wr_idx_r + IDXW'(1);
          end
          if (item_reload_r) begin
            use_prog = 1'b1;
            res_dir  = 1'b1;
            pg_rem   = rx_dec;
          end
        end
        REQ_XFER_DONE: begin
          res_load   = 1'b1;
          wr_idx_nxt = '0;
          if (rx_rem_r != 16'd0) begin
            reading_nxt = 1'b1;
            use_prog    = 1'b1;
            res_dir     = 1'b1;
            res_start   = 1'b1;
            pg_rem      = rx_rem_r;
          end else begin
            res_act = ACT_STOP;
          end
        end
        REQ_STOP: begin
          res_load    = 1'b1;
          res_act     = ACT_CLR_STOP;
          res_last    = !(reading_r && (cur_cnt != '0));
          del_idx_nxt = '0;
          del_cnt_nxt = cur_cnt;
        end
        REQ_NACK: begin
          res_load = 1'b1;
          res_act  = ACT_CLR_NACK;
        end
        default: begin
          res_load = 1'b0;
        end
      endcase
    end else if (cmd.prog2) begin
      // Write reload after a transmit ready: counts what is still left.
      res_load = 1'b1;
      use_prog = 1'b1;
      pg_rem   = tx_rem_r;
    end else if (cmd.deliver) begin
      res_load    = 1'b1;
      res_act     = ACT_DELIVER;
      res_rx      = rd_data_r;
      res_last    = status.del_last;
      del_idx_nxt = del_idx_r + IDXW'(1);
    end

    if (use_prog) begin
      res_act = ACT_PROG;
    end else begin
      res_addr = 7'd0;
    end
  end

  assign res_reload = use_prog && (pg_rem > 16'(MAX_CHUNK));
  assign res_chunk  = !use_prog ? 8'd0 : (res_reload ? 8'(MAX_CHUNK) : pg_rem[7:0]);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_req_r    <= in_tuser;
      item_addr_r   <= in_tdata[6:0];
      item_scount_r <= in_tdata[22:7];
      item_rcount_r <= in_tdata[38:23];
      item_busy_r   <= in_tdata[39];
      item_reload_r <= in_tdata[40];
      item_tx_r     <= in_tdata[48:41];
      item_rx_r     <= in_tdata[56:49];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reading_r   <= 1'b0;
      held_addr_r <= 7'd0;
      tx_rem_r    <= 16'd0;
      rx_rem_r    <= 16'd0;
      rx_total_r  <= 16'd0;
      wr_idx_r    <= '0;
      del_idx_r   <= '0;
      del_cnt_r   <= '0;
    end else begin
      reading_r   <= reading_nxt;
      held_addr_r <= held_addr_nxt;
      tx_rem_r    <= tx_rem_nxt;
      rx_rem_r    <= rx_rem_nxt;
      rx_total_r  <= rx_total_nxt;
      wr_idx_r    <= wr_idx_nxt;
      del_idx_r   <= del_idx_nxt;
      del_cnt_r   <= del_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx_r[AW-1:0]] <= item_rx_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[del_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_tuser_r <= res_act;
      out_tlast_r <= res_last;
      out_tdata_r <= {5'd0, res_ovf, res_rx, res_start, res_addr, res_dir,
                      res_reload, res_chunk, res_tx};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

`default_nettype wire

FILE: rtl/i2c_seq_ctrl.sv
// Controller state machine of the I2C master transfer sequencer.
// Depends on i2c_seq_pkg; drives the datapath through seq_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module i2c_seq_ctrl
  import i2c_seq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire seq_status_t status,
  output seq_cmd_t         cmd
);

  seq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.slot_free) begin
          if (status.more_tx) begin
            state_nxt = ST_TX_PROG;
          end else if (status.more_rx) begin
            state_nxt = ST_RD_ADDR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TX_PROG: begin
        if (status.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_ADDR: begin
        state_nxt = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (status.slot_free) begin
          state_nxt = status.del_last ? ST_IDLE : ST_RD_ADDR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.load_item = in_tvalid;
      end
      ST_EXEC:    cmd.exec    = status.slot_free;
      ST_TX_PROG: cmd.prog2   = status.slot_free;
      ST_RD_ADDR: cmd.rd_en   = 1'b1;
      ST_DELIVER: cmd.deliver = status.slot_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: controller plus datapath.
// Depends on i2c_seq_pkg, i2c_seq_ctrl, i2c_seq_dp and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_transfer_sequencer_assert.svh"

// Turns a start request or one I2C controller event per input beat into the
// register actions a master driver performs, one result beat each, with
// out_tlast on the final beat of an input. Items are taken one at a time:
// an item is latched when it is taken, and its first result is placed in the
// output register from the execute state once the output is free. A
// transmit ready with reload places its second result from the transmit
// program state. A stop after a read walks the receive store through its
// registered read port, a read state and a delivery state per byte. The output
// register lets the next item be taken while the last result still waits.
module i2c_master_transfer_sequencer
  import i2c_seq_pkg::*;
#(
  parameter int RX_STORE_DEPTH = 32,
  parameter int MAX_CHUNK      = 255
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // slave_address[6:0], send_count[22:7], receive_count[38:23],
  // bus_busy[39], reload_pending[40], tx_byte[48:41], rx_byte[56:49]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type[2:0]
  input  wire logic [REQ_W-1:0]       in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tx_data[7:0], chunk_count[15:8], reload_flag[16], read_direction[17],
  // target_address[24:18], start_flag[25], rx_data[33:26], overflow[34]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // action[2:0]
  output logic [ACT_W-1:0]            out_tuser,
  output logic                        out_tlast
);

  seq_cmd_t    cmd;
  seq_status_t status;

  i2c_seq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  i2c_seq_dp #(
    .RX_STORE_DEPTH (RX_STORE_DEPTH),
    .MAX_CHUNK      (MAX_CHUNK)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // An accepted item is never followed by another in the next cycle.
  `I2CSEQ_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready, "item overlap")
  // The start flag only rides on a program count beat.
  `I2CSEQ_ASSERT_SAME(a_start_prog, clk, rst_n, out_tvalid && out_tdata[25], out_tuser == ACT_PROG, "start flag outside program")
  // A dropped byte is reported only on the result of a byte received event.
  `I2CSEQ_ASSERT_SAME(a_ovf_kind, clk, rst_n, out_tvalid && out_tdata[34], (out_tuser == ACT_NONE || out_tuser == ACT_PROG) && out_tlast, "overflow on wrong beat")

endmodule

`default_nettype wire
